FILE: design/cabc_pkg.sv
// Package with AES constants and byte functions for the credential block codec.
`timescale 1ns / 1ps
package cabc_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'h01;
	localparam logic [15:0] TRAILER_VALUE = 16'h0748;
	localparam logic [2:0] MAX_ENCODE_SERIAL = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LONG_SERIAL = 2'd1;
	localparam logic [1:0] ST_BAD_HEADER = 2'd2;

	localparam logic [0:0] OP_ENCODE = 1'b0;
	localparam logic [0:0] OP_DECODE = 1'b1;

	// Forward S-box as a constant table.
	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Inverse S-box as a constant table.
	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Forward column mix on one 32-bit column, byte 0 in the top bits.
	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	// Inverse column mix: premultiply by {4,0,5,0}-style step then forward mix.
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, u, v;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		u = xtime(xtime(a0 ^ a2));
		v = xtime(xtime(a1 ^ a3));
		inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction

endpackage

FILE: design/credential_aes_block_codec_core.sv
// Credential block codec top level: AES-128 with one shared round unit.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  op, serial_*, *_in, block_*
// out       output     out_valid / out_ready status, cipher_*, *_out, trailer
// cfg       input      cfg_we               cfg_index, cfg_data
//
// Encode loads, runs ten rounds on the shared round unit with on-the-fly key
// expansion, then formats; a serial over MAX_ENCODE_SERIAL skips the rounds.
// Decode first runs the key schedule forward to reach the last round key,
// then ten inverse rounds.
// Reset clears the site key and the control state. A result holds in the
// output register until taken; the input stays stalled until then.
`timescale 1ns / 1ps
module credential_aes_block_codec_core #(
	parameter int SERIAL_BYTES = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [63:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic [8*SERIAL_BYTES-1:0] serial_bytes,
	input  logic [2:0]                serial_length,
	input  logic [23:0]               card_in,
	input  logic [15:0]               facility_in,
	input  logic [3:0]                region_in,
	input  logic [3:0]                issue_in,
	input  logic [63:0]               block_high,
	input  logic [63:0]               block_low,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [63:0]               cipher_high,
	output logic [63:0]               cipher_low,
	output logic [23:0]               card_out,
	output logic [15:0]               facility_out,
	output logic [3:0]                region_out,
	output logic [3:0]                issue_out,
	output logic                      trailer_unusual
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_KEYF = 3'd1;
	localparam logic [2:0] S_ENC = 3'd2;
	localparam logic [2:0] S_DEC = 3'd3;
	localparam logic [2:0] S_FMT = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;
	localparam int SW = 8 * SERIAL_BYTES;

	logic [2:0]   state_q;
	logic [3:0]   round_q;
	logic [7:0]   rcon_q;
	logic [127:0] key_q;
	logic [127:0] st_q;
	logic         op_q;
	logic [63:0]  skh_q, skl_q;

	// Site key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skh_q <= '0;
			skl_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) skh_q <= cfg_data;
			else skl_q <= cfg_data;
		end
	end

	// Diversified key: clamp length and XOR the serial prefix into the site key.
	logic [2:0]   len_c;
	logic [127:0] div_key;
	always_comb begin
		len_c = (serial_length > 3'(SERIAL_BYTES)) ? 3'(SERIAL_BYTES) : serial_length;
		div_key = {skh_q, skl_q};
		for (int i = 0; i < SERIAL_BYTES; i++) begin
			if (3'(i) < len_c) div_key[127-8*i -: 8] = div_key[127-8*i -: 8] ^ serial_bytes[SW-1-8*i -: 8];
		end
	end

	// Encode plain block.
	logic [127:0] plain;
	always_comb begin
		plain = {cabc_pkg::HEADER_BYTE, card_in, facility_in, region_in, issue_in, 24'h0,
			32'h0, cabc_pkg::TRAILER_VALUE};
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < len_c) plain[47-8*i -: 8] = serial_bytes[SW-1-8*i -: 8];
		end
	end

	// Key schedule step forward and backward.
	logic [31:0]  kw3, kgf, kgb;
	logic [127:0] key_fwd, key_bwd;
	logic [7:0]   rcon_b;
	always_comb begin
		kw3 = key_q[31:0];
		kgf = {cabc_pkg::SBOX[kw3[23:16]] ^ rcon_q, cabc_pkg::SBOX[kw3[15:8]],
			cabc_pkg::SBOX[kw3[7:0]], cabc_pkg::SBOX[kw3[31:24]]};
		key_fwd[127:96] = key_q[127:96] ^ kgf;
		key_fwd[95:64]  = key_q[95:64] ^ key_fwd[127:96];
		key_fwd[63:32]  = key_q[63:32] ^ key_fwd[95:64];
		key_fwd[31:0]   = key_q[31:0] ^ key_fwd[63:32];
		// Step back: previous rcon is current halved in GF(2^8).
		rcon_b = rcon_q[0] ? ((rcon_q ^ 8'h1b) >> 1) | 8'h80 : rcon_q >> 1;
		key_bwd[31:0]   = key_q[31:0] ^ key_q[63:32];
		key_bwd[63:32]  = key_q[63:32] ^ key_q[95:64];
		key_bwd[95:64]  = key_q[95:64] ^ key_q[127:96];
		kgb = {cabc_pkg::SBOX[key_bwd[23:16]] ^ rcon_b, cabc_pkg::SBOX[key_bwd[15:8]],
			cabc_pkg::SBOX[key_bwd[7:0]], cabc_pkg::SBOX[key_bwd[31:24]]};
		key_bwd[127:96] = key_q[127:96] ^ kgb;
	end

	// Shared round unit; encode uses the next round key, decode the previous one.
	logic [127:0] sh, sb, mc, enc_nx, ish, isb, ak, dec_nx;
	logic         last_enc, last_dec;
	always_comb begin
		last_enc = (round_q == 4'd10);
		last_dec = (round_q == 4'd1);
		for (int i = 0; i < 16; i++) begin
			sb[127-8*i -: 8] = cabc_pkg::SBOX[st_q[127-8*i -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sh[127-8*(4*c+r) -: 8] = sb[127-8*(4*((c+r)%4)+r) -: 8];
				ish[127-8*(4*((c+r)%4)+r) -: 8] = st_q[127-8*(4*c+r) -: 8];
			end
		end
		for (int c = 0; c < 4; c++) mc[127-32*c -: 32] = cabc_pkg::mix_col(sh[127-32*c -: 32]);
		enc_nx = (last_enc ? sh : mc) ^ key_fwd;
		for (int i = 0; i < 16; i++) isb[127-8*i -: 8] = cabc_pkg::INV_SBOX[ish[127-8*i -: 8]];
		ak = isb ^ key_bwd;
		for (int c = 0; c < 4; c++) begin
			dec_nx[127-32*c -: 32] = last_dec ? ak[127-32*c -: 32] :
				cabc_pkg::inv_mix_col(ak[127-32*c -: 32]);
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			round_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						round_q <= 4'd1;
						if (op == cabc_pkg::OP_ENCODE && len_c > cabc_pkg::MAX_ENCODE_SERIAL) begin
							state_q <= S_OUT;
							out_valid <= 1'b1;
						end else if (op == cabc_pkg::OP_ENCODE) state_q <= S_ENC;
						else state_q <= S_KEYF;
					end
				end
				S_KEYF: begin
					// The round count stays at ten so that ten inverse rounds follow.
					if (round_q == 4'd10) state_q <= S_DEC;
					else round_q <= round_q + 4'd1;
				end
				S_ENC: begin
					round_q <= round_q + 4'd1;
					if (last_enc) state_q <= S_FMT;
				end
				S_DEC: begin
					round_q <= round_q - 4'd1;
					if (last_dec) state_q <= S_FMT;
				end
				S_FMT: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
						out_valid <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= op;
				key_q <= div_key;
				rcon_q <= 8'h01;
				st_q <= (op == cabc_pkg::OP_ENCODE) ? plain ^ div_key : {block_high, block_low};
				{cipher_high, cipher_low, card_out, facility_out, region_out, issue_out,
					trailer_unusual} <= '0;
				status <= (op == cabc_pkg::OP_ENCODE && len_c > cabc_pkg::MAX_ENCODE_SERIAL) ?
					cabc_pkg::ST_LONG_SERIAL : cabc_pkg::ST_OK;
			end
			S_KEYF: begin
				key_q <= key_fwd;
				rcon_q <= cabc_pkg::xtime(rcon_q);
				if (round_q == 4'd10) st_q <= st_q ^ key_fwd;
			end
			S_ENC: begin
				st_q <= enc_nx;
				key_q <= key_fwd;
				rcon_q <= cabc_pkg::xtime(rcon_q);
			end
			S_DEC: begin
				st_q <= dec_nx;
				key_q <= key_bwd;
				rcon_q <= rcon_b;
			end
			S_FMT: begin
				if (op_q == cabc_pkg::OP_ENCODE) begin
					status <= cabc_pkg::ST_OK;
					{cipher_high, cipher_low} <= st_q;
				end else if (st_q[127:120] != cabc_pkg::HEADER_BYTE) begin
					status <= cabc_pkg::ST_BAD_HEADER;
				end else begin
					status <= cabc_pkg::ST_OK;
					card_out <= st_q[119:96];
					facility_out <= st_q[95:80];
					region_out <= st_q[79:76];
					issue_out <= st_q[75:72];
					trailer_unusual <= (st_q[15:0] != cabc_pkg::TRAILER_VALUE);
				end
			end
			default: ;
		endcase
	end

endmodule
